[src/qfrm_pkg.sv]
package qfrm_pkg;

   // fixed-point format of matrix elements and quaternion parts
   localparam int FRAC_BITS = 14;
   localparam int ELEM_W    = 16;
   localparam int QW_W      = 15;
   localparam int MAG_MAX   = 32767;

   // one plus or minus three elements, signed
   localparam int ONE_W  = FRAC_BITS + 2;
   localparam int SUM_W  = ((ONE_W > ELEM_W) ? ONE_W : ELEM_W) + 2;
   // clamped sum, unsigned
   localparam int S_W    = SUM_W - 1;
   // radicand padded to a whole number of two-bit-per-stage steps
   localparam int RAD_W  = ((S_W + FRAC_BITS + 3) / 4) * 4;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int MAG_W  = ROOT_W - 1;

   // root bits resolved per pipeline stage
   localparam int BITS_PER_STAGE = 2;
   localparam int SQRT_STAGES    = ROOT_W / BITS_PER_STAGE;
   // input register, sum register, root stages, output register
   localparam int LATENCY        = SQRT_STAGES + 3;

   localparam int NUM_LANES = 4;
   localparam int LANE_W    = 0;
   localparam int LANE_X    = 1;
   localparam int LANE_Y    = 2;
   localparam int LANE_Z    = 3;

   localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;

   // one square root in flight
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_lane_type;

   // everything that travels down the root pipeline for one request
   typedef struct packed {
      root_lane_type [NUM_LANES-1:0] lane;
      logic                          neg_x;
      logic                          neg_y;
      logic                          neg_z;
   } pipe_type;

endpackage

[src/qfrm_sums.sv]
module qfrm_sums
   import qfrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [ELEM_W-1:0] m00,
   input  logic signed [ELEM_W-1:0] m01,
   input  logic signed [ELEM_W-1:0] m02,
   input  logic signed [ELEM_W-1:0] m10,
   input  logic signed [ELEM_W-1:0] m11,
   input  logic signed [ELEM_W-1:0] m12,
   input  logic signed [ELEM_W-1:0] m20,
   input  logic signed [ELEM_W-1:0] m21,
   input  logic signed [ELEM_W-1:0] m22,
   output logic                     out_valid,
   output pipe_type                 out_pipe
);

   logic                     valid_ff;
   logic signed [ELEM_W-1:0] m00_ff, m01_ff, m02_ff, m10_ff, m11_ff;
   logic signed [ELEM_W-1:0] m12_ff, m20_ff, m21_ff, m22_ff;
   logic signed [SUM_W-1:0]  a_ext, b_ext, c_ext, one_ext;
   logic signed [SUM_W-1:0]  sum_w, sum_x, sum_y, sum_z;
   logic        [S_W-1:0]    s_w, s_x, s_y, s_z;
   pipe_type                 pipe_in;
   pipe_type                 pipe_ff;
   logic                     pipe_valid_ff;

   function automatic logic [S_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
      logic [S_W-1:0] r;
      r = s[SUM_W-1] ? '0 : s[S_W-1:0];
      return r;
   endfunction

   function automatic root_lane_type seed(input logic [S_W-1:0] s);
      root_lane_type l;
      l.rad  = RAD_W'(s) << FRAC_BITS;
      l.rem  = '0;
      l.root = '0;
      return l;
   endfunction

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         m00_ff <= m00; m01_ff <= m01; m02_ff <= m02;
         m10_ff <= m10; m11_ff <= m11; m12_ff <= m12;
         m20_ff <= m20; m21_ff <= m21; m22_ff <= m22;
      end
   end

   // diagonal sums, clamped at zero, and signs of the off-diagonal differences
   always_comb begin
      one_ext = $signed(ONE_SUM);
      a_ext   = SUM_W'(m00_ff);
      b_ext   = SUM_W'(m11_ff);
      c_ext   = SUM_W'(m22_ff);
      sum_w   = one_ext + a_ext + b_ext + c_ext;
      sum_x   = one_ext + a_ext - b_ext - c_ext;
      sum_y   = one_ext - a_ext + b_ext - c_ext;
      sum_z   = one_ext - a_ext - b_ext + c_ext;
      s_w     = clamp(sum_w);
      s_x     = clamp(sum_x);
      s_y     = clamp(sum_y);
      s_z     = clamp(sum_z);
      pipe_in.lane[LANE_W] = seed(s_w);
      pipe_in.lane[LANE_X] = seed(s_x);
      pipe_in.lane[LANE_Y] = seed(s_y);
      pipe_in.lane[LANE_Z] = seed(s_z);
      pipe_in.neg_x = m21_ff < m12_ff;
      pipe_in.neg_y = m20_ff < m02_ff;
      pipe_in.neg_z = m10_ff < m01_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= valid_ff;
      end
      pipe_ff <= pipe_in;
   end

   assign out_valid = pipe_valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

[src/qfrm_root_stage.sv]
module qfrm_root_stage
   import qfrm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   output logic     out_valid,
   output pipe_type out_pipe
);

   pipe_type pipe_in;
   pipe_type pipe_ff;
   logic     valid_ff;

   // restoring square root, two result bits per lane
   always_comb begin
      logic [RAD_W-1:0]  d;
      logic [REM_W-1:0]  r;
      logic [ROOT_W-1:0] q;
      logic [REM_W-1:0]  acc;
      logic [REM_W:0]    diff;
      pipe_in = in_pipe;
      for (int ln = 0; ln < NUM_LANES; ln++) begin
         d = in_pipe.lane[ln].rad;
         r = in_pipe.lane[ln].rem;
         q = in_pipe.lane[ln].root;
         for (int st = 0; st < BITS_PER_STAGE; st++) begin
            acc  = {r[REM_W-3:0], d[RAD_W-1 -: 2]};
            diff = {1'b0, acc} - {1'b0, q, 2'b01};
            if (!diff[REM_W]) begin
               r = diff[REM_W-1:0];
               q = {q[ROOT_W-2:0], 1'b1};
            end else begin
               r = acc;
               q = {q[ROOT_W-2:0], 1'b0};
            end
            d = {d[RAD_W-3:0], 2'b00};
         end
         pipe_in.lane[ln].rad  = d;
         pipe_in.lane[ln].rem  = r;
         pipe_in.lane[ln].root = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

[src/qfrm_out.sv]
module qfrm_out
   import qfrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  pipe_type                 in_pipe,
   output logic                     out_valid,
   output logic        [QW_W-1:0]   quat_w,
   output logic signed [ELEM_W-1:0] quat_x,
   output logic signed [ELEM_W-1:0] quat_y,
   output logic signed [ELEM_W-1:0] quat_z
);

   logic                     valid_ff;
   logic        [QW_W-1:0]   w_in, w_ff;
   logic signed [ELEM_W-1:0] x_in, x_ff, y_in, y_ff, z_in, z_ff;

   // halve the root and saturate to the part width
   function automatic logic [QW_W-1:0] half_sat(input logic [ROOT_W-1:0] root);
      logic [MAG_W-1:0] mag;
      logic [QW_W-1:0]  r;
      mag = root[ROOT_W-1:1];
      r   = (32'(mag) > 32'(MAG_MAX)) ? QW_W'(MAG_MAX) : QW_W'(mag);
      return r;
   endfunction

   function automatic logic [ELEM_W-1:0] apply_sign(input logic [QW_W-1:0] mag,
                                                    input logic neg);
      logic [ELEM_W-1:0] v;
      v = ELEM_W'(mag);
      return neg ? (ELEM_W'(0) - v) : v;
   endfunction

   always_comb begin
      w_in = half_sat(in_pipe.lane[LANE_W].root);
      x_in = apply_sign(half_sat(in_pipe.lane[LANE_X].root), in_pipe.neg_x);
      y_in = apply_sign(half_sat(in_pipe.lane[LANE_Y].root), in_pipe.neg_y);
      z_in = apply_sign(half_sat(in_pipe.lane[LANE_Z].root), in_pipe.neg_z);
   end

   // result register and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      w_ff <= w_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_valid = valid_ff;
   assign quat_w    = w_ff;
   assign quat_x    = x_ff;
   assign quat_y    = y_ff;
   assign quat_z    = z_ff;

endmodule

[src/quaternion_from_rotation_matrix.sv]
// channel   | ports                         | handshake
// ----------+-------------------------------+-------------------------------------
// request   | req_m00 .. req_m22            | taken when start is high, busy low
// result    | rsp_quat_w/x/y/z              | one-cycle strobe rsp_valid
//
// a request can enter every cycle while busy is low; each result passes through
// the input register, sum register, eight root stages and output register
// the latency is set by the 16-bit square root, two root bits per stage
// busy is high only while reset is asserted; reset clears every valid bit
// the receiver cannot stall, so the pipeline always advances
module quaternion_from_rotation_matrix
   import qfrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_m00,
   input  logic signed [ELEM_W-1:0] req_m01,
   input  logic signed [ELEM_W-1:0] req_m02,
   input  logic signed [ELEM_W-1:0] req_m10,
   input  logic signed [ELEM_W-1:0] req_m11,
   input  logic signed [ELEM_W-1:0] req_m12,
   input  logic signed [ELEM_W-1:0] req_m20,
   input  logic signed [ELEM_W-1:0] req_m21,
   input  logic signed [ELEM_W-1:0] req_m22,
   output logic                     rsp_valid,
   output logic        [QW_W-1:0]   rsp_quat_w,
   output logic signed [ELEM_W-1:0] rsp_quat_x,
   output logic signed [ELEM_W-1:0] rsp_quat_y,
   output logic signed [ELEM_W-1:0] rsp_quat_z
);

   logic     accept;
   logic     stage_valid [SQRT_STAGES+1];
   pipe_type stage_pipe  [SQRT_STAGES+1];

   assign busy   = reset;
   assign accept = start && !busy;

   // request capture and diagonal sums
   qfrm_sums u_sums (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .m00       (req_m00),
      .m01       (req_m01),
      .m02       (req_m02),
      .m10       (req_m10),
      .m11       (req_m11),
      .m12       (req_m12),
      .m20       (req_m20),
      .m21       (req_m21),
      .m22       (req_m22),
      .out_valid (stage_valid[0]),
      .out_pipe  (stage_pipe[0])
   );

   // square root pipeline, four lanes side by side
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
      qfrm_root_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_pipe   (stage_pipe[g]),
         .out_valid (stage_valid[g+1]),
         .out_pipe  (stage_pipe[g+1])
      );
   end

   // halving, signs and result register
   qfrm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[SQRT_STAGES]),
      .in_pipe   (stage_pipe[SQRT_STAGES]),
      .out_valid (rsp_valid),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

endmodule

[src/qfrm_checker.sv]
module qfrm_checker
   import qfrm_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic signed [ELEM_W-1:0] req_m00,
   input logic signed [ELEM_W-1:0] req_m01,
   input logic signed [ELEM_W-1:0] req_m02,
   input logic signed [ELEM_W-1:0] req_m10,
   input logic signed [ELEM_W-1:0] req_m11,
   input logic signed [ELEM_W-1:0] req_m12,
   input logic signed [ELEM_W-1:0] req_m20,
   input logic signed [ELEM_W-1:0] req_m21,
   input logic signed [ELEM_W-1:0] req_m22,
   input logic                     rsp_valid,
   input logic        [QW_W-1:0]   rsp_quat_w,
   input logic signed [ELEM_W-1:0] rsp_quat_x,
   input logic signed [ELEM_W-1:0] rsp_quat_y,
   input logic signed [ELEM_W-1:0] rsp_quat_z
);

   logic ident;

   // identity matrix request
   assign ident = start && !busy &&
                  req_m00 == 16'sd16384 && req_m11 == 16'sd16384 &&
                  req_m22 == 16'sd16384 && req_m01 == 16'sd0 && req_m02 == 16'sd0 &&
                  req_m10 == 16'sd0 && req_m12 == 16'sd0 && req_m20 == 16'sd0 &&
                  req_m21 == 16'sd0;

   // exactly one result per request, at fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, LATENCY))
      else $error("result strobe does not match request latency");

   // identity gives the unit quaternion
   a_identity: assert property (@(posedge clock) disable iff (reset)
      $past(ident, LATENCY) |->
         rsp_quat_w == 15'd16384 && rsp_quat_x == 16'sd0 &&
         rsp_quat_y == 16'sd0 && rsp_quat_z == 16'sd0)
      else $error("identity matrix did not give the unit quaternion");

   // saturated magnitudes keep vector parts off the most negative code
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_x != -16'sd32768 && rsp_quat_y != -16'sd32768 &&
                    rsp_quat_z != -16'sd32768)
      else $error("vector part out of range");

   // requests are refused only under reset
   a_busy: assert property (@(posedge clock)
      busy == reset)
      else $error("busy outside reset");

endmodule

bind quaternion_from_rotation_matrix qfrm_checker u_checker (.*);

[sim/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qfrm_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int PHASE_LEN      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int UNIT           = 1 << FRAC_BITS;

   // how the elements of one random matrix are drawn
   typedef enum int {
      ELEM_UNIT,
      ELEM_ANY,
      ELEM_EDGE
   } elem_kind_type;

   // how an off-diagonal element relates to its mirror
   typedef enum int {
      PAIR_EQUAL,
      PAIR_SKEW,
      PAIR_FREE
   } pair_kind_type;

   typedef struct packed {
      logic [ELEM_W-1:0] m00;
      logic [ELEM_W-1:0] m01;
      logic [ELEM_W-1:0] m02;
      logic [ELEM_W-1:0] m10;
      logic [ELEM_W-1:0] m11;
      logic [ELEM_W-1:0] m12;
      logic [ELEM_W-1:0] m20;
      logic [ELEM_W-1:0] m21;
      logic [ELEM_W-1:0] m22;
   } matrix_type;

   typedef struct packed {
      logic [QW_W-1:0]   w;
      logic [ELEM_W-1:0] x;
      logic [ELEM_W-1:0] y;
      logic [ELEM_W-1:0] z;
   } quat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   matrix_type        req_mat = '0;
   logic              rsp_valid;
   logic [QW_W-1:0]   rsp_quat_w;
   logic [ELEM_W-1:0] rsp_quat_x;
   logic [ELEM_W-1:0] rsp_quat_y;
   logic [ELEM_W-1:0] rsp_quat_z;

   matrix_type pending_mats[$];
   quat_type   expected_quats[$];

   logic req_accepted = 1'b0;
   int   issued_cnt   = 0;
   int   accepted_cnt = 0;
   int   result_cnt   = 0;
   int   directed_cnt = 0;
   int   total_cnt    = 0;
   int   error_cnt    = 0;
   int   stall_cycles = 0;

   quaternion_from_rotation_matrix u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_m00    (req_mat.m00),
      .req_m01    (req_mat.m01),
      .req_m02    (req_mat.m02),
      .req_m10    (req_mat.m10),
      .req_m11    (req_mat.m11),
      .req_m12    (req_mat.m12),
      .req_m20    (req_mat.m20),
      .req_m21    (req_mat.m21),
      .req_m22    (req_mat.m22),
      .rsp_valid  (rsp_valid),
      .rsp_quat_w (rsp_quat_w),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z)
   );

   // clock
   always #(CLK_PERIOD / 2) clock = ~clock;

   // floor(sqrt(s * 2^FRAC_BITS)) / 2, zero for non-positive sums, saturated
   function automatic int quat_magnitude(int s);
      longint radicand;
      longint root;
      longint trial;
      if (s <= 0) return 0;
      radicand = longint'(s) << FRAC_BITS;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand) root = trial;
      end
      root = root >>> 1;
      return (root > MAG_MAX) ? MAG_MAX : int'(root);
   endfunction

   // a zero difference counts as positive
   function automatic logic [ELEM_W-1:0] signed_part(int mag, int diff);
      return (diff < 0) ? ELEM_W'(-mag) : ELEM_W'(mag);
   endfunction

   // expected quaternion for one matrix
   function automatic quat_type matrix_to_quat(matrix_type m);
      int       d00, d11, d22;
      quat_type q;
      d00 = int'($signed(m.m00));
      d11 = int'($signed(m.m11));
      d22 = int'($signed(m.m22));
      q.w = QW_W'(quat_magnitude(UNIT + d00 + d11 + d22));
      q.x = signed_part(quat_magnitude(UNIT + d00 - d11 - d22),
                        int'($signed(m.m21)) - int'($signed(m.m12)));
      q.y = signed_part(quat_magnitude(UNIT - d00 + d11 - d22),
                        int'($signed(m.m20)) - int'($signed(m.m02)));
      q.z = signed_part(quat_magnitude(UNIT - d00 - d11 + d22),
                        int'($signed(m.m10)) - int'($signed(m.m01)));
      return q;
   endfunction

   function automatic matrix_type make_matrix(int a00, int a01, int a02,
                                              int a10, int a11, int a12,
                                              int a20, int a21, int a22);
      matrix_type m;
      m.m00 = ELEM_W'(a00);
      m.m01 = ELEM_W'(a01);
      m.m02 = ELEM_W'(a02);
      m.m10 = ELEM_W'(a10);
      m.m11 = ELEM_W'(a11);
      m.m12 = ELEM_W'(a12);
      m.m20 = ELEM_W'(a20);
      m.m21 = ELEM_W'(a21);
      m.m22 = ELEM_W'(a22);
      return m;
   endfunction

   function automatic logic [ELEM_W-1:0] random_elem(elem_kind_type kind);
      unique case (kind)
         ELEM_UNIT: return ELEM_W'(int'($urandom_range(2 * UNIT)) - UNIT);
         ELEM_ANY:  return ELEM_W'($urandom);
         default: begin
            unique case ($urandom_range(6))
               0:       return ELEM_W'(-32768);
               1:       return ELEM_W'(-UNIT);
               2:       return ELEM_W'(-1);
               3:       return ELEM_W'(0);
               4:       return ELEM_W'(1);
               5:       return ELEM_W'(UNIT);
               default: return ELEM_W'(32767);
            endcase
         end
      endcase
   endfunction

   // mirror element: equal, negated or left alone
   function automatic logic [ELEM_W-1:0] pair_partner(logic [ELEM_W-1:0] first,
                                                      logic [ELEM_W-1:0] second);
      unique case (pair_kind_type'($urandom_range(2)))
         PAIR_EQUAL: return first;
         PAIR_SKEW:  return -first;
         default:    return second;
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type    m;
      elem_kind_type kind;
      int            roll;
      roll = $urandom_range(99);
      kind = (roll < 50) ? ELEM_UNIT : (roll < 75) ? ELEM_ANY : ELEM_EDGE;
      m.m00 = random_elem(kind);
      m.m01 = random_elem(kind);
      m.m02 = random_elem(kind);
      m.m10 = random_elem(kind);
      m.m11 = random_elem(kind);
      m.m12 = random_elem(kind);
      m.m20 = random_elem(kind);
      m.m21 = random_elem(kind);
      m.m22 = random_elem(kind);
      m.m12 = pair_partner(m.m21, m.m12);
      m.m02 = pair_partner(m.m20, m.m02);
      m.m01 = pair_partner(m.m10, m.m01);
      return m;
   endfunction

   task automatic report_error(string msg);
      $display("error: %s", msg);
      error_cnt++;
   endtask

   // request driver, changes inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_accepted) begin
         if ((issued_cnt == directed_cnt || issued_cnt == PHASE_LEN ||
              issued_cnt == 2 * PHASE_LEN) && expected_quats.size() != 0) begin
            // hold off until the pipeline has drained
            start <= 1'b0;
         end else if (pending_mats.size() != 0 &&
                      $urandom_range(99) >= ((issued_cnt < PHASE_LEN) ? 20 :
                                             (issued_cnt < 2 * PHASE_LEN) ? 76 : 0)) begin
            req_mat    <= pending_mats.pop_front();
            start      <= 1'b1;
            issued_cnt <= issued_cnt + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor, samples on the rising edge
   always @(posedge clock) begin
      quat_type exp_q;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         // compare result against the oldest prediction
         if (rsp_valid) begin
            if (expected_quats.size() == 0) begin
               report_error($sformatf("result %0d arrived with no request pending",
                                      result_cnt));
            end else begin
               exp_q = expected_quats.pop_front();
               if (rsp_quat_w !== exp_q.w)
                  report_error($sformatf("result %0d quat_w got %0d expected %0d",
                                         result_cnt, rsp_quat_w, exp_q.w));
               if (rsp_quat_x !== exp_q.x)
                  report_error($sformatf("result %0d quat_x got %0d expected %0d",
                                         result_cnt, $signed(rsp_quat_x), $signed(exp_q.x)));
               if (rsp_quat_y !== exp_q.y)
                  report_error($sformatf("result %0d quat_y got %0d expected %0d",
                                         result_cnt, $signed(rsp_quat_y), $signed(exp_q.y)));
               if (rsp_quat_z !== exp_q.z)
                  report_error($sformatf("result %0d quat_z got %0d expected %0d",
                                         result_cnt, $signed(rsp_quat_z), $signed(exp_q.z)));
            end
            result_cnt <= result_cnt + 1;
         end
         // predict each accepted request
         req_accepted <= start && !busy;
         if (start && !busy) begin
            expected_quats.push_back(matrix_to_quat(req_mat));
            accepted_cnt <= accepted_cnt + 1;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      // identity, zero and the three half turns
      pending_mats.push_back(make_matrix(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT));
      pending_mats.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_mats.push_back(make_matrix(UNIT, 0, 0, 0, -UNIT, 0, 0, 0, -UNIT));
      pending_mats.push_back(make_matrix(-UNIT, 0, 0, 0, UNIT, 0, 0, 0, -UNIT));
      pending_mats.push_back(make_matrix(-UNIT, 0, 0, 0, -UNIT, 0, 0, 0, UNIT));
      // negative trace clamps w
      pending_mats.push_back(make_matrix(-UNIT, 0, 0, 0, -UNIT, 0, 0, 0, -UNIT));
      // uniform fills at the unit and word limits
      pending_mats.push_back(make_matrix(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT,
                                         UNIT, UNIT, UNIT));
      pending_mats.push_back(make_matrix(-UNIT, -UNIT, -UNIT, -UNIT, -UNIT, -UNIT,
                                         -UNIT, -UNIT, -UNIT));
      pending_mats.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                         32767, 32767, 32767));
      pending_mats.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                         -32768, -32768, -32768));
      // largest and most negative diagonal
      pending_mats.push_back(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
      pending_mats.push_back(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
      // all differences positive, then all negative
      pending_mats.push_back(make_matrix(0, -UNIT, -UNIT, UNIT, 0, -UNIT, UNIT, UNIT, 0));
      pending_mats.push_back(make_matrix(0, UNIT, UNIT, -UNIT, 0, UNIT, -UNIT, -UNIT, 0));
      // differences beyond the element width, one of them zero
      pending_mats.push_back(make_matrix(0, -32768, 32767, -32768, 0, -32768,
                                         -32768, 32767, 0));
      // quarter turns about z, x and y
      pending_mats.push_back(make_matrix(0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT));
      pending_mats.push_back(make_matrix(UNIT, 0, 0, 0, 0, -UNIT, 0, UNIT, 0));
      pending_mats.push_back(make_matrix(0, 0, UNIT, 0, UNIT, 0, -UNIT, 0, 0));
      // sums just below zero and exactly zero
      pending_mats.push_back(make_matrix(-UNIT, 0, 0, 0, 0, 0, 0, 0, -1));
      pending_mats.push_back(make_matrix(-UNIT, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_cnt = pending_mats.size();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_mats.push_back(random_matrix());
      end
      total_cnt = pending_mats.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every request and result, then let the pipeline empty
      do @(negedge clock);
      while (accepted_cnt != total_cnt || expected_quats.size() != 0);
      repeat (LATENCY + 4) @(negedge clock);

      if (error_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[quaternion_from_rotation_matrix.f]
src/qfrm_pkg.sv
src/qfrm_sums.sv
src/qfrm_root_stage.sv
src/qfrm_out.sv
src/quaternion_from_rotation_matrix.sv
src/qfrm_checker.sv
sim/testbench.sv
